// ===== src/rgc_pkg.sv =====
package rgc_pkg;

  // fixed field widths
  localparam int unsigned BYTE_WIDTH   = 8;
  localparam int unsigned GRADE_WIDTH  = 5;
  localparam int unsigned REPORT_WIDTH = 16;

  // scaled coleman-liau weights: 0.0588*100*100, 0.296*100*100, 15.8*100
  localparam int unsigned K_LETTER   = 588;
  localparam int unsigned K_SENTENCE = 2960;
  localparam int unsigned K_WORD     = 1580;
  localparam int unsigned K_DEN      = 100;

  localparam int unsigned GRADE_MAX  = 16;
  localparam int unsigned QUOT_BITS  = 6;
  localparam int unsigned STEP_WIDTH = 3;

  // datapath operations
  localparam int unsigned OP_WIDTH = 4;
  localparam logic [OP_WIDTH-1:0] OP_NONE  = 4'd0;
  localparam logic [OP_WIDTH-1:0] OP_ACC_L = 4'd1;
  localparam logic [OP_WIDTH-1:0] OP_ACC_S = 4'd2;
  localparam logic [OP_WIDTH-1:0] OP_ACC_W = 4'd3;
  localparam logic [OP_WIDTH-1:0] OP_DEN   = 4'd4;
  localparam logic [OP_WIDTH-1:0] OP_LOAD  = 4'd5;
  localparam logic [OP_WIDTH-1:0] OP_OVF   = 4'd6;
  localparam logic [OP_WIDTH-1:0] OP_DIV   = 4'd7;
  localparam logic [OP_WIDTH-1:0] OP_OUT   = 4'd8;

  localparam logic [BYTE_WIDTH-1:0] CH_TAB   = 8'd9;
  localparam logic [BYTE_WIDTH-1:0] CH_CR    = 8'd13;
  localparam logic [BYTE_WIDTH-1:0] CH_SPACE = 8'd32;
  localparam logic [BYTE_WIDTH-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_WIDTH-1:0] CH_BANG  = 8'h21;
  localparam logic [BYTE_WIDTH-1:0] CH_QUERY = 8'h3F;
  localparam logic [BYTE_WIDTH-1:0] CH_UP_A  = 8'h41;
  localparam logic [BYTE_WIDTH-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [BYTE_WIDTH-1:0] CH_LO_A  = 8'h61;
  localparam logic [BYTE_WIDTH-1:0] CH_LO_Z  = 8'h7A;

  typedef struct packed {
    logic [BYTE_WIDTH-1:0] char_byte;
    logic                  end_of_text;
  } rgc_in_t;

  typedef struct packed {
    logic [GRADE_WIDTH-1:0]  grade_level;
    logic [REPORT_WIDTH-1:0] letter_total;
    logic [REPORT_WIDTH-1:0] word_total;
    logic [REPORT_WIDTH-1:0] sentence_total;
  } rgc_out_t;

  typedef struct packed {
    logic [OP_WIDTH-1:0]   op;
    logic [STEP_WIDTH-1:0] step;
    logic                  count_en;
  } rgc_cmd_t;

  function automatic logic is_letter(input logic [BYTE_WIDTH-1:0] b);
    return (b >= CH_UP_A && b <= CH_UP_Z) || (b >= CH_LO_A && b <= CH_LO_Z);
  endfunction

  function automatic logic is_space(input logic [BYTE_WIDTH-1:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic is_mark(input logic [BYTE_WIDTH-1:0] b);
    return (b == CH_DOT) || (b == CH_BANG) || (b == CH_QUERY);
  endfunction

endpackage

// ===== src/rgc_ctrl.sv =====
module rgc_ctrl
  import rgc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     byte_valid,
  input  logic     end_of_text,
  output logic     byte_stall,
  output logic     grade_valid,
  input  logic     grade_stall,
  output rgc_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACC_L = 4'd1;
  localparam logic [3:0] S_ACC_S = 4'd2;
  localparam logic [3:0] S_ACC_W = 4'd3;
  localparam logic [3:0] S_DEN   = 4'd4;
  localparam logic [3:0] S_LOAD  = 4'd5;
  localparam logic [3:0] S_OVF   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]            state, state_next;
  logic [STEP_WIDTH-1:0] step, step_next;
  logic                  grade_valid_next;
  logic                  out_free;

  assign byte_stall = (state != S_IDLE);
  assign out_free   = !grade_valid || !grade_stall;

  always_comb begin
    state_next       = state;
    step_next        = step;
    grade_valid_next = grade_valid && grade_stall;
    cmd.op           = OP_NONE;
    cmd.step         = step;
    cmd.count_en     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (byte_valid) begin
          cmd.count_en = 1'b1;
          if (end_of_text) begin
            state_next = S_ACC_L;
          end
        end
      end
      S_ACC_L: begin
        cmd.op     = OP_ACC_L;
        state_next = S_ACC_S;
      end
      S_ACC_S: begin
        cmd.op     = OP_ACC_S;
        state_next = S_ACC_W;
      end
      S_ACC_W: begin
        cmd.op     = OP_ACC_W;
        state_next = S_DEN;
      end
      S_DEN: begin
        cmd.op     = OP_DEN;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.op     = OP_LOAD;
        state_next = S_OVF;
      end
      S_OVF: begin
        cmd.op     = OP_OVF;
        step_next  = STEP_WIDTH'(QUOT_BITS - 1);
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op    = OP_DIV;
        step_next = step - STEP_WIDTH'(1);
        if (step == '0) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.op           = OP_OUT;
          grade_valid_next = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      step        <= '0;
      grade_valid <= 1'b0;
    end else begin
      state       <= state_next;
      step        <= step_next;
      grade_valid <= grade_valid_next;
    end
  end

endmodule

// ===== src/rgc_dp.sv =====
module rgc_dp
  import rgc_pkg::*;
#(
  parameter int unsigned CW = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rgc_cmd_t              cmd,
  input  logic [BYTE_WIDTH-1:0] char_byte,
  output rgc_out_t              result
);

  localparam int unsigned AW = CW + 14;
  localparam int unsigned DW = CW + 16;
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

  logic [CW-1:0]        letter_count, space_count, sentence_count;
  logic [CW-1:0]        words;
  logic signed [AW-1:0] acc;
  logic [DW-1:0]        den, rem, div, trial;
  logic [QUOT_BITS-1:0] quot;
  logic                 neg, ovf;
  logic [GRADE_WIDTH-1:0] grade;

  assign words = (space_count == COUNT_MAX) ? COUNT_MAX : space_count + CW'(1);
  assign trial = div << cmd.step;

  // counters, cleared once the result has been captured
  always_ff @(posedge clk) begin
    if (rst || cmd.op == OP_OUT) begin
      letter_count   <= '0;
      space_count    <= '0;
      sentence_count <= '0;
    end else if (cmd.count_en) begin
      if (is_letter(char_byte)) begin
        if (letter_count != COUNT_MAX) letter_count <= letter_count + CW'(1);
      end else if (is_space(char_byte)) begin
        if (space_count != COUNT_MAX) space_count <= space_count + CW'(1);
      end else if (is_mark(char_byte)) begin
        if (sentence_count != COUNT_MAX) sentence_count <= sentence_count + CW'(1);
      end
    end
  end

  always_comb begin
    if (neg) begin
      grade = '0;
    end else if (ovf || quot > QUOT_BITS'(GRADE_MAX)) begin
      grade = GRADE_WIDTH'(GRADE_MAX);
    end else begin
      grade = quot[GRADE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACC_L: acc <= $signed(AW'(letter_count) * AW'(K_LETTER));
      OP_ACC_S: acc <= acc - $signed(AW'(sentence_count) * AW'(K_SENTENCE));
      OP_ACC_W: acc <= acc - $signed(AW'(words) * AW'(K_WORD));
      OP_DEN:   den <= DW'(words) * DW'(K_DEN);
      OP_LOAD: begin
        neg  <= acc[AW-1];
        rem  <= (DW'($unsigned(acc)) << 1) + den;
        div  <= den << 1;
        quot <= '0;
      end
      OP_OVF:   ovf <= (rem >= (div << QUOT_BITS));
      OP_DIV: begin
        if (rem >= trial) begin
          rem             <= rem - trial;
          quot[cmd.step]  <= 1'b1;
        end
      end
      OP_OUT: begin
        result.grade_level    <= grade;
        result.letter_total   <= (|(letter_count >> REPORT_WIDTH)) ?
                                 {REPORT_WIDTH{1'b1}} : REPORT_WIDTH'(letter_count);
        result.word_total     <= (|(words >> REPORT_WIDTH)) ?
                                 {REPORT_WIDTH{1'b1}} : REPORT_WIDTH'(words);
        result.sentence_total <= (|(sentence_count >> REPORT_WIDTH)) ?
                                 {REPORT_WIDTH{1'b1}} : REPORT_WIDTH'(sentence_count);
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/readability_grade_counter.sv =====
// Coleman-Liau readability grade of a byte stream. Text bytes stream in one
// transfer per cycle while idle; letters, whitespace (tab, newline, vertical
// tab, form feed, carriage return, space) and sentence marks ('.', '!', '?')
// are counted in saturating counters of COUNT_WIDTH bits. The byte flagged
// end_of_text is counted too, and then the input stalls while a sequencer runs
// the grade through one constant multiplier (three weighted terms and the
// denominator, one per cycle) and a restoring divider that resolves one
// quotient bit per cycle. The grade is round((588L - 2960S - 1580W) / (100W))
// with halves away from zero, clamped to 0..16; the totals are reported with
// saturation at 65535. A finished result sits in an output register, so the
// next text may stream in while the result waits to be taken; after a second
// final byte the input stays stalled until that register frees up.
module readability_grade_counter
  import rgc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  // text byte channel
  input  logic     byte_valid,
  output logic     byte_stall,
  input  rgc_in_t  byte_data,
  // result channel
  output logic     grade_valid,
  input  logic     grade_stall,
  output rgc_out_t grade_data
);

  // command bundle from the sequencer to the counters and arithmetic
  rgc_cmd_t cmd;

  // sequencer: byte acceptance, grade computation steps, result handoff
  rgc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .end_of_text (byte_data.end_of_text),
    .byte_stall  (byte_stall),
    .grade_valid (grade_valid),
    .grade_stall (grade_stall),
    .cmd         (cmd)
  );

  // counters, numerator accumulator, divider and output register
  rgc_dp #(
    .CW (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .char_byte (byte_data.char_byte),
    .result    (grade_data)
  );

endmodule

// ===== tb/rgc_checker.sv =====
`timescale 1ns / 1ps
module rgc_checker
  import rgc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     byte_valid,
  input  logic     byte_stall,
  input  rgc_in_t  byte_data,
  input  logic     grade_valid,
  input  logic     grade_stall,
  input  rgc_out_t grade_data,
  output int       fail_count,
  output int       grades_owed,
  output int       texts_checked
);

  localparam logic [REPORT_WIDTH-1:0] COUNT_TOP = '1;

  logic [REPORT_WIDTH-1:0] letters_seen;
  logic [REPORT_WIDTH-1:0] spaces_seen;
  logic [REPORT_WIDTH-1:0] marks_seen;
  rgc_out_t                pending_grades[$];

  function automatic logic [REPORT_WIDTH-1:0] sat_inc(input logic [REPORT_WIDTH-1:0] c);
    return (c == COUNT_TOP) ? c : c + 1'b1;
  endfunction

  // exact grade, halves away from zero, clamped
  function automatic logic [GRADE_WIDTH-1:0] coleman_liau_grade(input longint letters,
                                                                input longint words,
                                                                input longint marks);
    longint num;
    longint den;
    longint q;
    num = longint'(K_LETTER) * letters - longint'(K_SENTENCE) * marks
          - longint'(K_WORD) * words;
    den = longint'(K_DEN) * words;
    if (num < 0) return '0;
    q = (2 * num + den) / (2 * den);
    return (q > longint'(GRADE_MAX)) ? GRADE_WIDTH'(GRADE_MAX) : q[GRADE_WIDTH-1:0];
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    rgc_out_t                want;
    rgc_out_t                got;
    logic [BYTE_WIDTH-1:0]   b;
    logic [REPORT_WIDTH-1:0] words;
    if (rst) begin
      letters_seen = '0;
      spaces_seen = '0;
      marks_seen = '0;
      pending_grades.delete();
      fail_count = 0;
      texts_checked = 0;
    end else begin
      if (grade_valid && !grade_stall) begin
        got = grade_data;
        if (pending_grades.size() == 0) begin
          $error("grade transfer with no text pending: grade_level %0d", got.grade_level);
          fail_count++;
        end else begin
          want = pending_grades.pop_front();
          check_field("grade_level", 32'(want.grade_level), 32'(got.grade_level));
          check_field("letter_total", 32'(want.letter_total), 32'(got.letter_total));
          check_field("word_total", 32'(want.word_total), 32'(got.word_total));
          check_field("sentence_total", 32'(want.sentence_total),
                      32'(got.sentence_total));
          texts_checked++;
        end
      end
      if (byte_valid && !byte_stall) begin
        b = byte_data.char_byte;
        if ((b >= CH_UP_A && b <= CH_UP_Z) || (b >= CH_LO_A && b <= CH_LO_Z))
          letters_seen = sat_inc(letters_seen);
        else if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
          spaces_seen = sat_inc(spaces_seen);
        else if (b == CH_DOT || b == CH_BANG || b == CH_QUERY)
          marks_seen = sat_inc(marks_seen);
        if (byte_data.end_of_text) begin
          words = sat_inc(spaces_seen);
          want.grade_level = coleman_liau_grade(longint'(letters_seen), longint'(words),
                                                longint'(marks_seen));
          want.letter_total = letters_seen;
          want.word_total = words;
          want.sentence_total = marks_seen;
          pending_grades.push_back(want);
          letters_seen = '0;
          spaces_seen = '0;
          marks_seen = '0;
        end
      end
    end
    grades_owed = pending_grades.size();
  end

endmodule

// ===== tb/tb_readability_grade_counter.sv =====
`timescale 1ns / 1ps
module tb_readability_grade_counter;
  import rgc_pkg::*;

  // run shape
  localparam int RANDOM_UNTIL = 740;     // bytes sent before the quiet tail
  localparam int TAIL_BYTES   = 60;      // quiet random bytes at the very end
  localparam int HOLD_AFTER   = 300;     // bytes sent before the long result hold
  localparam int LONG_HOLD    = 400;     // cycles the result side holds off
  localparam int DRAIN_CYCLES = 32;      // well past the grade sequence
  localparam int CYCLE_LIMIT  = 1000000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     byte_valid = 1'b0;
  logic     byte_stall;
  rgc_in_t  byte_data = '0;
  logic     grade_valid;
  logic     grade_stall = 1'b0;
  rgc_out_t grade_data;

  int fail_count;
  int grades_owed;
  int texts_checked;
  int bytes_sent = 0;
  int texts_sent = 0;
  int cycle_count = 0;
  bit calm = 1'b0;            // no idling on either side once set
  bit long_hold_done = 1'b0;

  // both sides of the letter and tab..carriage return ranges, plus space, marks and other bytes
  logic [BYTE_WIDTH-1:0] edge_bytes [23] = '{
    8'h00, 8'h08, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR, 8'h0E, CH_SPACE, CH_BANG,
    CH_DOT, CH_QUERY, 8'h40, CH_UP_A, CH_UP_Z, 8'h5B, 8'h60, CH_LO_A, CH_LO_Z,
    8'h7B, 8'h7F, 8'h80, 8'hFF
  };

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  readability_grade_counter u_top (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .grade_valid(grade_valid),
    .grade_stall(grade_stall),
    .grade_data (grade_data)
  );

  rgc_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_data    (byte_data),
    .grade_valid  (grade_valid),
    .grade_stall  (grade_stall),
    .grade_data   (grade_data),
    .fail_count   (fail_count),
    .grades_owed  (grades_owed),
    .texts_checked(texts_checked)
  );

  // one byte transfer, then maybe an idle burst on the sending side
  task automatic send_byte(input logic [BYTE_WIDTH-1:0] b, input logic eot, input bit gaps);
    int unsigned pause;
    byte_valid <= 1'b1;
    byte_data.char_byte <= b;
    byte_data.end_of_text <= eot;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
    if (eot) texts_sent++;
    if (gaps && !calm && $urandom_range(5) == 0) begin
      pause = $urandom_range(8, 1);
      byte_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
  endtask

  // draw one byte from a weighted mix of the classes; the rest is any byte
  function automatic logic [BYTE_WIDTH-1:0] pick_byte(input int letter_pct,
                                                      input int space_pct,
                                                      input int mark_pct);
    int unsigned r;
    int unsigned k;
    r = $urandom_range(99);
    if (r < letter_pct) begin
      return BYTE_WIDTH'(($urandom_range(1) ? CH_UP_A : CH_LO_A) + $urandom_range(25));
    end else if (r < letter_pct + space_pct) begin
      // space is the likeliest single separator, each control whitespace byte less so
      k = $urandom_range(6);
      return (k > 4) ? CH_SPACE : BYTE_WIDTH'(CH_TAB + k);
    end else if (r < letter_pct + space_pct + mark_pct) begin
      case ($urandom_range(2))
        0: return CH_DOT;
        1: return CH_BANG;
        default: return CH_QUERY;
      endcase
    end
    return BYTE_WIDTH'($urandom_range(255));
  endfunction

  // one whole text; the mix varies per text so grades span the full range
  task automatic send_text(input bit gaps);
    int len;
    int letter_pct;
    int space_pct;
    int mark_pct;
    if ($urandom_range(11) == 0) begin
      // 15 letters, one space, one mark: the grade lands exactly on 13.5
      for (int i = 0; i < 17; i++) begin
        if (i == 7) send_byte(CH_SPACE, 1'b0, gaps);
        else if (i == 16) send_byte(CH_DOT, 1'b1, gaps);
        else send_byte(pick_byte(100, 0, 0), 1'b0, gaps);
      end
    end else begin
      len = ($urandom_range(3) == 0) ? $urandom_range(60, 25) : $urandom_range(24, 1);
      letter_pct = $urandom_range(90, 30);
      space_pct = $urandom_range(30, 5);
      mark_pct = $urandom_range(15);
      for (int i = 0; i < len; i++)
        send_byte(pick_byte(letter_pct, space_pct, mark_pct), i == len - 1, gaps);
    end
  endtask

  // result side: random stall bursts in windows of varying density,
  // plus one long hold that backs the block up into its input
  initial begin : result_sink
    int unsigned odds;
    int          window;
    int unsigned burst;
    odds = 0;
    window = 0;
    forever begin
      @(posedge clk);
      if (window == 0) begin
        window = 128;
        case ($urandom_range(2))
          0: odds = 0;
          1: odds = 3;
          default: odds = 15;
        endcase
      end
      window--;
      if (!long_hold_done && bytes_sent >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        grade_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        grade_stall <= 1'b0;
      end else if (!calm && odds != 0 && $urandom_range(odds) == 0) begin
        burst = $urandom_range(8, 1);
        grade_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        grade_stall <= 1'b0;
      end
    end
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d grades still owed", cycle_count, grades_owed);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int tail_start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: single-byte texts, then every class boundary in one text
    send_byte(CH_UP_A, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    foreach (edge_bytes[i])
      send_byte(edge_bytes[i], i == $size(edge_bytes) - 1, 1'b1);

    // random texts, idling on both sides, some texts sent back to back
    while (bytes_sent < RANDOM_UNTIL)
      send_text($urandom_range(3) != 0);

    // quiet tail: a short stretch of ordinary texts with no idling
    calm = 1'b1;
    tail_start = bytes_sent;
    while (bytes_sent < tail_start + TAIL_BYTES) send_text(1'b0);
    byte_valid <= 1'b0;

    // let the last final byte reach the checker, then wait for its grade
    @(posedge clk);
    wait (grades_owed == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d bytes in %0d texts sent, %0d grades compared", bytes_sent, texts_sent,
             texts_checked);
    $display("covered class edges, rounding ties, random texts with idling, a %0d-cycle hold",
             LONG_HOLD);
    if (fail_count == 0 && grades_owed == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
